// ----- hdl/cpd_pkg.sv -----
// shared types and constants for the clutch position to duty block
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int POS_W      = 10;
  localparam int DUTY_W     = 16;
  localparam int REGION_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FULL_SCALE = 1024;

  // duty region codes
  localparam logic [REGION_W-1:0] REGION_CLOSED = 2'd0;
  localparam logic [REGION_W-1:0] REGION_OPEN   = 2'd1;
  localparam logic [REGION_W-1:0] REGION_INTERP = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_MID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_CLOSED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_OPEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CLOSED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_OPEN   = 3'd4;

  // configuration reset values
  localparam logic [POS_W-1:0]  RST_BIAS_MID    = 10'd512;
  localparam logic [POS_W-1:0]  RST_POS_CLOSED  = 10'd650;
  localparam logic [POS_W-1:0]  RST_POS_OPEN    = 10'd900;
  localparam logic [DUTY_W-1:0] RST_DUTY_CLOSED = 16'd3000;
  localparam logic [DUTY_W-1:0] RST_DUTY_OPEN   = 16'd13000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic sum_upd;
    logic fold;
    logic cmp;
    logic mul;
    logic div_step;
    logic load_out;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic interp;
  } sts_t;

endpackage

// ----- hdl/cpd_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cpd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 10,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/cpd_ctrl.sv -----
// controller state machine for the clutch position to duty block
`timescale 1ns / 1ps

module cpd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  input  cpd_pkg::sts_t sts_i,
  output cpd_pkg::cmd_t cmd_o
);

  import cpd_pkg::*;

  localparam int CNT_W = $clog2(DUTY_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DUTY_W - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // output register can take a new word when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum_upd = 1'b1;
        state_d       = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = sts_i.interp ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/cpd_dpath.sv -----
// datapath: sample ring, running sum, fold, compare and interpolation divider
`timescale 1ns / 1ps

module cpd_dpath #(
  parameter int AVG_COUNT = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cpd_pkg::cmd_t                  cmd_i,
  output cpd_pkg::sts_t                  sts_o,
  input  logic [cpd_pkg::POS_W-1:0]      clutch_position_i,
  input  logic                           cfg_we_i,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [cpd_pkg::DUTY_W-1:0]     duty_cycle_o,
  output logic [cpd_pkg::REGION_W-1:0]   duty_region_o
);

  import cpd_pkg::*;

  localparam int SLOT_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
  localparam int SUM_W  = $clog2(1023 * AVG_COUNT + 1);
  localparam int F_W    = $clog2(FULL_SCALE * AVG_COUNT + 1);
  localparam int SPAN_W = SUM_W;
  localparam int P_W    = SPAN_W + DUTY_W;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_COUNT - 1);
  localparam logic [F_W-1:0]    N_F       = F_W'(AVG_COUNT);
  localparam logic [F_W-1:0]    FULL_N    = F_W'(FULL_SCALE * AVG_COUNT);
  localparam logic [SPAN_W-1:0] N_S       = SPAN_W'(AVG_COUNT);

  // configuration registers
  logic [POS_W-1:0]  bias_mid_q, pos_closed_q, pos_open_q;
  logic [DUTY_W-1:0] duty_closed_q, duty_open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_mid_q    <= RST_BIAS_MID;
      pos_closed_q  <= RST_POS_CLOSED;
      pos_open_q    <= RST_POS_OPEN;
      duty_closed_q <= RST_DUTY_CLOSED;
      duty_open_q   <= RST_DUTY_OPEN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BIAS_MID:    bias_mid_q    <= cfg_data_i[POS_W-1:0];
        CFG_POS_CLOSED:  pos_closed_q  <= cfg_data_i[POS_W-1:0];
        CFG_POS_OPEN:    pos_open_q    <= cfg_data_i[POS_W-1:0];
        CFG_DUTY_CLOSED: duty_closed_q <= cfg_data_i;
        CFG_DUTY_OPEN:   duty_open_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sample ring, slot pointer and running sum
  logic [POS_W-1:0]     sample_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [AVG_COUNT-1:0] ring_vld_q;
  logic [SUM_W-1:0]     sum_q;
  logic [POS_W-1:0]     ring_rdata;
  logic [POS_W-1:0]     old_sample;

  cpd_ram #(
    .WIDTH (POS_W),
    .DEPTH (AVG_COUNT)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sum_upd),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.accept),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  // slots never written read as zero through their valid bits
  assign old_sample = ring_vld_q[slot_q] ? ring_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      ring_vld_q <= '0;
      sum_q      <= '0;
    end else if (cmd_i.sum_upd) begin
      sum_q              <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
      ring_vld_q[slot_q] <= 1'b1;
      slot_q             <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= clutch_position_i;
    end
  end

  // fold about full scale and scale the thresholds by the ring depth
  logic [F_W-1:0]    fold_q, pcn_q, pon_q;
  logic [F_W-1:0]    sum_f;
  logic [SPAN_W-1:0] span_q;
  logic              span_zero_q;

  assign sum_f = F_W'(sum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fold) begin
      fold_q      <= (sum_f < F_W'(bias_mid_q) * N_F) ? FULL_N - sum_f : sum_f;
      pcn_q       <= F_W'(pos_closed_q) * N_F;
      pon_q       <= F_W'(pos_open_q) * N_F;
      span_q      <= SPAN_W'(pos_open_q - pos_closed_q) * N_S;
      span_zero_q <= (pos_open_q == pos_closed_q);
    end
  end

  // region decision, closed threshold first
  logic [REGION_W-1:0] region_d, region_q;
  logic [SPAN_W-1:0]   x_q;
  logic                desc_q;

  always_comb begin
    priority if (fold_q < pcn_q) begin
      region_d = REGION_CLOSED;
    end else if (fold_q > pon_q) begin
      region_d = REGION_OPEN;
    end else begin
      region_d = REGION_INTERP;
    end
  end

  assign sts_o.interp = (region_d == REGION_INTERP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      region_q <= region_d;
      x_q      <= SPAN_W'(fold_q - pcn_q);
      desc_q   <= (duty_open_q < duty_closed_q);
    end
  end

  // product then restoring division, one quotient bit per cycle
  logic [DUTY_W-1:0] dduty;
  logic [P_W-1:0]    prod;
  logic [SPAN_W-1:0] rem_q;
  logic [DUTY_W-1:0] quo_q;
  logic [SPAN_W:0]   trial;
  logic              ge;

  assign dduty = desc_q ? duty_closed_q - duty_open_q : duty_open_q - duty_closed_q;
  assign prod  = P_W'(x_q) * P_W'(dduty);
  assign trial = {rem_q, quo_q[DUTY_W-1]};
  assign ge    = (trial >= {1'b0, span_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q <= prod[P_W-1:DUTY_W];
      quo_q <= prod[DUTY_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? SPAN_W'(trial - {1'b0, span_q}) : trial[SPAN_W-1:0];
      quo_q <= {quo_q[DUTY_W-2:0], ge};
    end
  end

  // final duty and output register
  logic [DUTY_W:0]   quo_up;
  logic [DUTY_W-1:0] duty_d, duty_q;
  logic [REGION_W-1:0] out_region_q;

  assign quo_up = {1'b0, quo_q} + {{DUTY_W{1'b0}}, (rem_q != '0)};

  always_comb begin
    unique case (region_q)
      REGION_CLOSED: duty_d = duty_closed_q;
      REGION_OPEN:   duty_d = duty_open_q;
      default: begin
        priority if (span_zero_q) begin
          duty_d = duty_closed_q;
        end else if (desc_q) begin
          duty_d = duty_closed_q - quo_up[DUTY_W-1:0];
        end else begin
          duty_d = duty_closed_q + quo_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      duty_q       <= duty_d;
      out_region_q <= region_q;
    end
  end

  assign duty_cycle_o  = duty_q;
  assign duty_region_o = out_region_q;

endmodule

// ----- hdl/clutch_position_to_duty.sv -----
// top level: clutch sensor moving average mapped to an actuator duty
`timescale 1ns / 1ps
//
//  channel   handshake                  payload
//  -------   -------------------------  ----------------------------------
//  in        in_valid_i / in_stall_o    clutch_position_i
//  out       out_valid_o / out_stall_i  duty_cycle_o, duty_region_o
//  cfg       cfg_we_i                   cfg_index_i, cfg_data_i
//
//  a word runs accept, sum update, fold and compare before the output load; an
//  interpolated word also runs multiply and the 16 step restoring divider
//  reset clears sample ring (per slot valid bits), pointer, sum; presets config
//  a finished word waits in the output register under out_stall_i while the
//  next input word is taken and processed; loading stalls only if it is full
//

module clutch_position_to_duty #(
  parameter int AVG_COUNT = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cpd_pkg::POS_W-1:0]      clutch_position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cpd_pkg::DUTY_W-1:0]     duty_cycle_o,
  output logic [cpd_pkg::REGION_W-1:0]   duty_region_o,
  input  logic                           cfg_we_i,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import cpd_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, sum update, fold, compare, multiply, divide, output
  cpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // ring, running sum, thresholds, divider and output register
  cpd_dpath #(
    .AVG_COUNT (AVG_COUNT)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .clutch_position_i (clutch_position_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .duty_cycle_o      (duty_cycle_o),
    .duty_region_o     (duty_region_o)
  );

endmodule

// ----- bench/cpd_checker.sv -----
// checker for the clutch position to duty block: watches the channels, predicts, compares
`timescale 1ns / 1ps

module cpd_checker #(
  parameter int AVG_COUNT = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [cpd_pkg::POS_W-1:0]      clutch_position_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [cpd_pkg::DUTY_W-1:0]     duty_cycle_i,
  input  logic [cpd_pkg::REGION_W-1:0]   duty_region_i,
  input  logic                           cfg_we_i,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  import cpd_pkg::*;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [REGION_W-1:0] region;
  } duty_word_t;

  // shadow configuration
  logic [POS_W-1:0]  bias_r;
  logic [POS_W-1:0]  closed_pos_r;
  logic [POS_W-1:0]  open_pos_r;
  logic [DUTY_W-1:0] closed_duty_r;
  logic [DUTY_W-1:0] open_duty_r;

  // shadow averaging state
  logic [POS_W-1:0] pos_ring [AVG_COUNT];
  int unsigned      ring_slot;
  logic [31:0]      pos_total;

  duty_word_t duty_q [$];
  duty_word_t want;
  int         fails;

  // sum to duty word, all on the sum so no fractions appear
  function automatic duty_word_t map_total(input logic [31:0] total);
    logic [63:0] folded, lo_lim, hi_lim, offs, span;
    duty_word_t  w;
    folded = 64'(total);
    if (folded < 64'(bias_r) * AVG_COUNT) folded = 64'(FULL_SCALE) * AVG_COUNT - folded;
    lo_lim = 64'(closed_pos_r) * AVG_COUNT;
    hi_lim = 64'(open_pos_r) * AVG_COUNT;
    if (folded < lo_lim) begin
      w.duty   = closed_duty_r;
      w.region = REGION_CLOSED;
    end else if (folded > hi_lim) begin
      w.duty   = open_duty_r;
      w.region = REGION_OPEN;
    end else begin
      w.region = REGION_INTERP;
      offs     = folded - lo_lim;
      span     = hi_lim - lo_lim;
      if (span == 64'd0) begin
        w.duty = closed_duty_r;
      end else if (open_duty_r >= closed_duty_r) begin
        w.duty = closed_duty_r
               + DUTY_W'((offs * (64'(open_duty_r) - 64'(closed_duty_r))) / span);
      end else begin
        // falling curve: the step down is rounded up so the result floors
        w.duty = closed_duty_r
               - DUTY_W'((offs * (64'(closed_duty_r) - 64'(open_duty_r)) + span - 64'd1)
                         / span);
      end
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_r        = RST_BIAS_MID;
      closed_pos_r  = RST_POS_CLOSED;
      open_pos_r    = RST_POS_OPEN;
      closed_duty_r = RST_DUTY_CLOSED;
      open_duty_r   = RST_DUTY_OPEN;
      for (int k = 0; k < AVG_COUNT; k++) pos_ring[k] = '0;
      ring_slot = 0;
      pos_total = '0;
      duty_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BIAS_MID:    bias_r        = cfg_data_i[POS_W-1:0];
          CFG_POS_CLOSED:  closed_pos_r  = cfg_data_i[POS_W-1:0];
          CFG_POS_OPEN:    open_pos_r    = cfg_data_i[POS_W-1:0];
          CFG_DUTY_CLOSED: closed_duty_r = cfg_data_i;
          CFG_DUTY_OPEN:   open_duty_r   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (duty_q.size() == 0) begin
          $error("duty word with nothing expected: duty_cycle %0d duty_region %0d",
                 duty_cycle_i, duty_region_i);
          fails++;
        end else begin
          want = duty_q.pop_front();
          if (duty_cycle_i !== want.duty) begin
            $error("duty_cycle mismatch: expected %0d, got %0d", want.duty, duty_cycle_i);
            fails++;
          end
          if (duty_region_i !== want.region) begin
            $error("duty_region mismatch: expected %0d, got %0d", want.region,
                   duty_region_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pos_total = pos_total - 32'(pos_ring[ring_slot]) + 32'(clutch_position_i);
        pos_ring[ring_slot] = clutch_position_i;
        ring_slot = (ring_slot + 1 == AVG_COUNT) ? 0 : ring_slot + 1;
        duty_q.push_back(map_total(pos_total));
      end
      fail_count_o <= fails;
      pending_o    <= duty_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// testbench top: clock, reset, stimulus and verdict for the clutch position to duty block
`timescale 1ns / 1ps

module tb_top;
  import cpd_pkg::*;

  localparam int AVG_COUNT  = 10;
  localparam int SEG_WORDS  = 100;
  localparam int SEGMENTS   = 7;
  localparam int HOLD_LEN   = 400;
  localparam int QUIET_MAX  = 4000;
  localparam int DRAIN_WAIT = 60;

  logic                  clk_i;
  logic                  rst_ni            = 1'b0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_stall_o;
  logic [POS_W-1:0]      clutch_position_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i       = 1'b0;
  logic [DUTY_W-1:0]     duty_cycle_o;
  logic [REGION_W-1:0]   duty_region_o;
  logic                  cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i        = '0;

  int fail_count;
  int pending;

  // traffic shaping shared with the receiver process
  bit calm      = 1'b0;
  bit hold_go   = 1'b0;
  bit hold_used = 1'b0;

  // configuration as last written, used only to aim the stimulus
  int cur_bias = RST_BIAS_MID;
  int cur_pc   = RST_POS_CLOSED;
  int cur_po   = RST_POS_OPEN;

  // drifting sensor level, so the average lingers near interesting points
  int level      = 0;
  int level_left = 0;

  clutch_position_to_duty #(
    .AVG_COUNT(AVG_COUNT)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .clutch_position_i(clutch_position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .duty_cycle_o     (duty_cycle_o),
    .duty_region_o    (duty_region_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  cpd_checker #(
    .AVG_COUNT(AVG_COUNT)
  ) u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .clutch_position_i(clutch_position_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .duty_cycle_i     (duty_cycle_o),
    .duty_region_i    (duty_region_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, one long hold-off on request, none while calm
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 19);
      end
    end
  end

  // ends the run when nothing moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL clutch_position_to_duty");
    $finish;
  end

  // offer one word, with random idle cycles first; returns at the accepting edge
  task automatic send_word(input logic [POS_W-1:0] pos);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    clutch_position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop offering and wait until every expected word has come out
  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
  endtask

  // position registers get random bits above their width, which must be ignored
  task automatic set_config(input int bias, input int pc, input int po,
                            input int dc, input int dopen);
    end_burst();
    cfg_put(CFG_BIAS_MID,    {6'($urandom), POS_W'(bias)});
    cfg_put(CFG_POS_CLOSED,  {6'($urandom), POS_W'(pc)});
    cfg_put(CFG_POS_OPEN,    {6'($urandom), POS_W'(po)});
    cfg_put(CFG_DUTY_CLOSED, DUTY_W'(dc));
    cfg_put(CFG_DUTY_OPEN,   DUTY_W'(dopen));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_bias = bias;
    cur_pc   = pc;
    cur_po   = po;
  endtask

  // sample near a level that jumps between thresholds, their mirrors, the bias point, the rails and random points
  task automatic pick_position(output logic [POS_W-1:0] pos);
    int v;
    if (level_left == 0) begin
      level_left = $urandom_range(5, 25);
      case ($urandom_range(0, 7))
        0:       level = cur_pc;
        1:       level = cur_po;
        2:       level = cur_bias;
        3:       level = FULL_SCALE - cur_pc;
        4:       level = FULL_SCALE - cur_po;
        5:       level = 0;
        6:       level = FULL_SCALE - 1;
        default: level = $urandom_range(0, FULL_SCALE - 1);
      endcase
    end
    level_left--;
    if ($urandom_range(0, 99) < 15) begin
      v = $urandom_range(0, FULL_SCALE - 1);
    end else begin
      v = level + int'($urandom_range(0, 16)) - 8;
    end
    if (v < 0) v = 0;
    if (v > FULL_SCALE - 1) v = FULL_SCALE - 1;
    pos = POS_W'(v);
  endtask

  initial begin : stimulus
    logic [POS_W-1:0] pos;
    int a, b, d1, d2;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty ring folds to full scale, then the top rail
    send_word(POS_W'(0));
    repeat (5) send_word(POS_W'(FULL_SCALE - 1));

    // equal thresholds hit exactly by the sum: zero span, closed duty, interpolated
    set_config(0, 512, 512, 65535, 0);
    for (int k = CFG_DUTY_OPEN + 1; k < (1 << CFG_IDX_W); k++) begin
      cfg_put(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_word(POS_W'(5));
    send_word(POS_W'(0));

    // falling duty curve over the full range
    set_config(0, 0, FULL_SCALE - 1, 65535, 0);
    send_word(POS_W'(700));
    send_word(POS_W'(300));
    send_word(POS_W'(FULL_SCALE - 1));

    // inverted thresholds with nearly everything folded
    set_config(FULL_SCALE - 1, 900, 100, 0, 65535);
    send_word(POS_W'(FULL_SCALE - 1));
    send_word(POS_W'(512));
    send_word(POS_W'(0));
    send_word(POS_W'(1));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      a  = $urandom_range(0, FULL_SCALE - 2);
      b  = $urandom_range(a + 1, FULL_SCALE - 1);
      d1 = $urandom_range(0, 65534);
      d2 = $urandom_range(d1, 65535);
      case (seg)
        0: set_config(RST_BIAS_MID, RST_POS_CLOSED, RST_POS_OPEN,
                      RST_DUTY_CLOSED, RST_DUTY_OPEN);
        1: set_config($urandom_range(0, FULL_SCALE - 1), a, b, d1, d2);
        2: set_config($urandom_range(0, FULL_SCALE - 1), a, b, d2, d1);
        3: set_config(0, 0, FULL_SCALE - 1, 0, 65535);
        4: set_config(FULL_SCALE - 1, FULL_SCALE - 1, FULL_SCALE - 1, 65535, 0);
        5: set_config($urandom_range(0, FULL_SCALE - 1), $urandom_range(0, FULL_SCALE - 1),
                      $urandom_range(0, FULL_SCALE - 1), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        default: set_config($urandom_range(0, FULL_SCALE - 1), a, a + 1,
                            $urandom_range(0, 65535), $urandom_range(0, 65535));
      endcase
      calm = (seg == 3);
      // long receiver hold-off while words keep coming, to back up the input
      if (seg == 1) hold_go = 1'b1;
      for (int i = 0; i < SEG_WORDS; i++) begin
        // sender pause until the pipeline has drained
        if (seg == 2 && i == SEG_WORDS / 2) end_burst();
        pick_position(pos);
        send_word(pos);
      end
    end

    calm = 1'b0;
    end_burst();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS clutch_position_to_duty");
    end else begin
      $display("FAIL clutch_position_to_duty");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/cpd_pkg.sv
hdl/cpd_ram.sv
hdl/cpd_ctrl.sv
hdl/cpd_dpath.sv
hdl/clutch_position_to_duty.sv
bench/cpd_checker.sv
bench/tb_top.sv
